// ===== sv/gas_pkg.sv =====
// shared types and constants for the geometric allocation sampler
package gas_pkg;

   localparam int unsigned RATE_W   = 31;
   localparam int unsigned BYTES_W  = 32;
   localparam int unsigned CNT_W    = 36;
   localparam int unsigned LCG_W    = 48;
   localparam int unsigned Q_W      = 27;
   localparam int unsigned LOG2_W   = 29;
   localparam int unsigned M_W      = 29;

   localparam logic [LCG_W-1:0] LCG_MULT = 48'h0005DEECE66D;
   localparam logic [LCG_W-1:0] LCG_ADD  = 48'h00000000000B;
   localparam logic [31:0]      LN2_Q32  = 32'hB17217F8;
   localparam logic [RATE_W-1:0] DEFAULT_RATE = 31'd524288;
   localparam logic [CNT_W-1:0]  DEFAULT_CNT  = 36'd524288;
   localparam logic [LOG2_W-1:0] LOG2_LIMIT   = 29'(26 * (1 << 24));

   // commands from controller to datapath
   typedef struct packed {
      logic load;      // capture input item and compare
      logic lcg_lo;    // lcg partial product, low word
      logic lcg_hi;    // lcg partial products, high part and add
      logic log_step;  // leading one, rom lookup, m
      logic mul_ln2;   // m * ln2
      logic mul_r_lo;  // p * rate, low part
      logic mul_r_hi;  // p * rate, high part
      logic finish;    // final countdown update
   } cmd_type;

   typedef struct packed {
      logic need_draw;  // item crossed countdown and rate is not one
   } sts_type;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_LCG  = 7'b0000010,
      ST_LOG  = 7'b0000100,
      ST_ROM  = 7'b0001000,
      ST_MUL  = 7'b0010000,
      ST_RATE = 7'b0100000,
      ST_DONE = 7'b1000000
   } state_type;

endpackage

// ===== sv/gas_if.sv =====
// valid/ready channel carrying one item
interface gas_if #(
   parameter int unsigned W = 1
) ();
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== sv/geometric_allocation_sampler.sv =====
// geometric allocation sampler top level
// without a draw an item is compared and finished; a draw adds lcg, table read and multiply steps
// one item is handled at a time; no new item is taken while one is still in flight
// a new item is accepted once the waiting result leaves, in that same cycle at the earliest
// reset (synchronous, active high): rate and countdown 524288, lcg state zero
module geometric_allocation_sampler #(
   parameter int unsigned LOG_TABLE_BITS = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [gas_pkg::RATE_W-1:0]   csr_write_data,
   gas_if.sink                          req,
   gas_if.source                        rsp
);

   logic [gas_pkg::RATE_W-1:0] rate_ff;
   gas_pkg::cmd_type           cmd;
   gas_pkg::sts_type           sts;
   logic                       sample_taken;
   logic [gas_pkg::CNT_W-1:0]  bytes_until_next;

   // rate register
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= gas_pkg::DEFAULT_RATE;
      end else if (csr_write_enable) begin
         rate_ff <= csr_write_data;
      end
   end

   gas_control u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   gas_datapath #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .allocation_bytes (req.data[63:32]),
      .bytes_before     (req.data[31:0]),
      .rate             (rate_ff),
      .sample_taken     (sample_taken),
      .bytes_until_next (bytes_until_next)
   );

   assign rsp.data = {sample_taken, bytes_until_next};

   // countdown never reaches zero
   a_cnt_nonzero: assert property (@(posedge clock) disable iff (reset)
      bytes_until_next != '0) else $error("countdown reached zero");

   // a result after a finish step
   a_rsp_after_finish: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp.valid) else $error("finish without result");

   // no new item while a load is in flight
   a_single_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !cmd.load) else $error("back to back load");

endmodule

// ===== sv/gas_log_rom.sv =====
// log2 mantissa table, Q0.24, filled by repeated squaring, registered read
module gas_log_rom #(
   parameter int unsigned LOG_TABLE_BITS = 10
) (
   input  logic                      clock,
   input  logic [LOG_TABLE_BITS-1:0] addr,
   output logic [23:0]               value
);

   localparam int unsigned DEPTH = 1 << LOG_TABLE_BITS;

   // squaring of a Q1.63 value, keeps 64 bits of the 128 bit product from its leading one down
   function automatic logic [24:0] rom_bits(input logic [LOG_TABLE_BITS-1:0] y);
      logic [63:0]  x;
      logic [127:0] sq;
      logic [24:0]  bits;
      x = 64'(({1'b1, y, 1'b1}) ) << (62 - LOG_TABLE_BITS);
      bits = '0;
      for (int i = 0; i < 25; i++) begin
         sq = 128'(x) * 128'(x);
         bits = {bits[23:0], sq[127]};
         if (sq[127]) begin
            x = sq[127:64];
         end else begin
            x = sq[126:63];
         end
      end
      return bits;
   endfunction

   function automatic logic [23:0] rom_val(input logic [LOG_TABLE_BITS-1:0] y);
      logic [25:0] r;
      r = ({1'b0, rom_bits(y)} + 26'd1) >> 1;
      return r[23:0];
   endfunction

   logic [23:0] rom_data [DEPTH];
   logic [23:0] value_ff;

   // constant table
   always_comb begin
      for (int k = 0; k < DEPTH; k++) begin
         rom_data[k] = rom_val(LOG_TABLE_BITS'(k));
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      value_ff <= rom_data[addr];
   end

   assign value = value_ff;

endmodule

// ===== sv/gas_datapath.sv =====
// datapath: countdown, lcg, log2 and interval arithmetic
module gas_datapath #(
   parameter int unsigned LOG_TABLE_BITS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  gas_pkg::cmd_type              cmd,
   output gas_pkg::sts_type              sts,
   input  logic [gas_pkg::BYTES_W-1:0]   allocation_bytes,
   input  logic [gas_pkg::BYTES_W-1:0]   bytes_before,
   input  logic [gas_pkg::RATE_W-1:0]    rate,
   output logic                          sample_taken,
   output logic [gas_pkg::CNT_W-1:0]     bytes_until_next
);

   logic [gas_pkg::CNT_W-1:0]  countdown_ff, countdown_in;
   logic [gas_pkg::LCG_W-1:0]  lcg_ff, lcg_in;
   logic [32:0]                total_ff;
   logic [gas_pkg::CNT_W-1:0]  over_ff;
   logic                       crossed_ff, rate_one_ff;
   logic [47:0]                part_ff;
   logic [gas_pkg::M_W-1:0]    m_ff;
   logic [60:0]                p_ff;
   logic [91:0]                plo_ff;
   logic [gas_pkg::CNT_W-1:0]  iv_ff;

   // compare sum with countdown
   logic [36:0] total_w;
   assign total_w = 37'(allocation_bytes) + 37'(bytes_before);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         total_ff    <= total_w[32:0];
         crossed_ff  <= total_w >= 37'(countdown_ff);
         over_ff     <= 36'(total_w - 37'(countdown_ff));
         rate_one_ff <= rate == gas_pkg::RATE_W'(1);
      end
   end

   assign sts.need_draw = crossed_ff && !rate_one_ff;

   // lcg advance over two steps: 48 bit mult split in halves
   always_ff @(posedge clock) begin
      if (cmd.lcg_lo) begin
         part_ff <= 48'(lcg_ff[23:0] * gas_pkg::LCG_MULT);
      end
   end

   always_comb begin
      lcg_in = lcg_ff;
      if (cmd.lcg_hi) begin
         lcg_in = part_ff + 48'({24'(lcg_ff[47:24] * gas_pkg::LCG_MULT[23:0]), 24'd0})
                  + gas_pkg::LCG_ADD;
      end
   end

   // leading one and table lookup, table read in the cycle before log_step
   logic [gas_pkg::Q_W-1:0]  q_w;
   logic [4:0]               e_w;
   logic [gas_pkg::Q_W-1:0]  frac_w;
   logic [LOG_TABLE_BITS-1:0] y_w;
   logic [23:0]              rom_w;
   logic [gas_pkg::LOG2_W-1:0] l2_w;
   logic [gas_pkg::Q_W+LOG_TABLE_BITS-1:0] fx_w;

   assign q_w = gas_pkg::Q_W'(lcg_ff[47:22]) + gas_pkg::Q_W'(1);

   always_comb begin
      e_w = '0;
      for (int i = 0; i < gas_pkg::Q_W; i++) begin
         if (q_w[i]) e_w = 5'(i);
      end
      frac_w = q_w & ~(gas_pkg::Q_W'(1) << e_w);
      fx_w = ({(gas_pkg::Q_W+LOG_TABLE_BITS)'(frac_w)} << LOG_TABLE_BITS) >> e_w;
      y_w = fx_w[LOG_TABLE_BITS-1:0];
      l2_w = {e_w, 24'd0} + gas_pkg::LOG2_W'(rom_w);
   end

   gas_log_rom #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_rom (
      .clock (clock),
      .addr  (y_w),
      .value (rom_w)
   );

   always_ff @(posedge clock) begin
      if (cmd.log_step) begin
         m_ff <= (l2_w < gas_pkg::LOG2_LIMIT) ? gas_pkg::LOG2_LIMIT - l2_w : '0;
      end
      if (cmd.mul_ln2) begin
         p_ff <= 61'(m_ff) * 61'(gas_pkg::LN2_Q32);
      end
      // p (61 bits) * rate (31 bits): low 31 bits of p first, then high 30
      if (cmd.mul_r_lo) begin
         plo_ff <= 92'(62'(p_ff[30:0]) * 62'(rate));
      end
      if (cmd.mul_r_hi) begin
         iv_ff <= 36'((plo_ff + {61'(p_ff[60:31]) * 61'(rate), 31'd0}) >> 56);
      end
   end

   // countdown update
   logic [gas_pkg::CNT_W-1:0] iv_w;
   assign iv_w = iv_ff + gas_pkg::CNT_W'(1);

   always_comb begin
      countdown_in = countdown_ff;
      if (cmd.finish) begin
         if (!crossed_ff) begin
            countdown_in = countdown_ff - 36'(total_ff);
         end else if (rate_one_ff) begin
            countdown_in = gas_pkg::CNT_W'(1);
         end else if (over_ff != '0 && iv_w > over_ff) begin
            countdown_in = iv_w - over_ff;
         end else begin
            countdown_in = iv_w;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         countdown_ff <= gas_pkg::DEFAULT_CNT;
         lcg_ff       <= '0;
      end else begin
         countdown_ff <= countdown_in;
         lcg_ff       <= lcg_in;
      end
      if (cmd.finish) begin
         sample_taken <= crossed_ff;
      end
   end

   assign bytes_until_next = countdown_ff;

endmodule

// ===== sv/gas_control.sv =====
// controller state machine sequencing one item
module gas_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  gas_pkg::sts_type sts,
   output gas_pkg::cmd_type cmd
);

   gas_pkg::state_type state_ff, state_in;
   logic               out_ff, out_in;
   logic               busy_ff, busy_in;
   logic [1:0]         cmd_phase_ff;

   assign req_ready = !busy_ff && (!out_ff || rsp_ready);
   assign rsp_valid = out_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      busy_in  = busy_ff;
      out_in   = out_ff && !rsp_ready;
      cmd      = '0;
      case (state_ff)
         gas_pkg::ST_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               busy_in  = 1'b1;
               state_in = gas_pkg::ST_LCG;
            end
         end
         gas_pkg::ST_LCG: begin
            if (sts.need_draw) begin
               cmd.lcg_lo = 1'b1;
               state_in   = gas_pkg::ST_LOG;
            end else begin
               state_in = gas_pkg::ST_DONE;
            end
         end
         gas_pkg::ST_LOG: begin
            cmd.lcg_hi = 1'b1;
            state_in   = gas_pkg::ST_ROM;
         end
         // table read of the new lcg value
         gas_pkg::ST_ROM: begin
            state_in = gas_pkg::ST_MUL;
         end
         gas_pkg::ST_MUL: begin
            cmd.log_step = 1'b1;
            state_in     = gas_pkg::ST_RATE;
         end
         gas_pkg::ST_RATE: begin
            cmd.mul_ln2 = 1'b1;
            state_in    = gas_pkg::ST_DONE;
         end
         gas_pkg::ST_DONE: begin
            if (!sts.need_draw || cmd_phase_ff == 2'd2) begin
               cmd.finish = 1'b1;
               out_in     = 1'b1;
               busy_in    = 1'b0;
               state_in   = gas_pkg::ST_IDLE;
            end else if (cmd_phase_ff == 2'd0) begin
               cmd.mul_r_lo = 1'b1;
            end else begin
               cmd.mul_r_hi = 1'b1;
            end
         end
         default: state_in = gas_pkg::ST_IDLE;
      endcase
   end

   // phase counter inside the final state for the rate multiply
   always_ff @(posedge clock) begin
      if (reset || state_ff != gas_pkg::ST_DONE) begin
         cmd_phase_ff <= '0;
      end else begin
         cmd_phase_ff <= cmd_phase_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gas_pkg::ST_IDLE;
         out_ff   <= 1'b0;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_ff   <= out_in;
         busy_ff  <= busy_in;
      end
   end

endmodule
